// File: rtl/core/pcds_pkg.sv
package pcds_pkg;

  // Largest post divider searched for a parallel panel on channel 0.
  localparam int unsigned MaxDivider = 127;

  // Field widths.
  localparam int unsigned ClkW   = 20;
  localparam int unsigned MW     = $clog2(MaxDivider + 1);
  localparam int unsigned NW     = 7;
  localparam int unsigned ErrW   = 28;
  localparam int unsigned ProdW  = MW + ClkW;

  // Serial divider operand widths. The dividend holds K * n, below 2^20, and the
  // divisor is m. DsW also holds the larger step size.
  localparam int unsigned DsW    = 13;
  localparam int unsigned DdW    = DsW + NW;
  localparam int unsigned DivCntW = $clog2(DdW);

  // PLL step sizes in kHz: both are 375 kHz times a power of two.
  localparam int unsigned KOdd     = 375;
  localparam int unsigned KShPlain = 3;
  localparam int unsigned KShDbl   = 4;
  localparam int unsigned KPlain   = KOdd << KShPlain;
  localparam int unsigned KDbl     = KOdd << KShDbl;

  // Quotient by 375 through a reciprocal scaled by 2^RecipShift. Over the window
  // where n fits, the shifted product stays below 48000 and the estimate is exact.
  localparam int unsigned QW         = 16;
  localparam int unsigned RqW        = 2 * QW;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipK     = ((1 << RecipShift) + KOdd - 1) / KOdd;

  // Multiplier range.
  localparam int unsigned NMin   = 9;
  localparam int unsigned NMax   = 127;

  // Channel divider ranges.
  localparam int unsigned ParLo  = 6;
  localparam int unsigned SerM   = 7;
  localparam int unsigned Ch1Lo  = 1;
  localparam int unsigned Ch1Hi  = 15;

  localparam logic [ErrW-1:0] NoFitError = 28'h0FFFFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic mul;
    logic set_dbl;
    logic next_m;
    logic div_start;
    logic cap_n;
    logic cmp;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic m_odd;
    logic m_last;
    logic dbl;
    logic div_busy;
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/core/pcds_cfg_if.sv
interface pcds_cfg_if;
  logic valid;
  logic ready;
  logic parallel_interface;

  modport source (output valid, output parallel_interface, input ready);
  modport sink (input valid, input parallel_interface, output ready);
endinterface

// File: rtl/core/pcds_in_if.sv
interface pcds_in_if;
  logic                      valid;
  logic                      ready;
  logic                      channel;
  logic [pcds_pkg::ClkW-1:0] pixel_clock_khz;

  modport source (output valid, output channel, output pixel_clock_khz, input ready);
  modport sink (input valid, input channel, input pixel_clock_khz, output ready);
endinterface

// File: rtl/core/pcds_out_if.sv
interface pcds_out_if;
  logic                      valid;
  logic                      ready;
  logic [6:0]                divider_m;
  logic [pcds_pkg::NW-1:0]   pll_n;
  logic                      doubled;
  logic [pcds_pkg::ErrW-1:0] error_khz;
  logic                      found;

  modport source (
    output valid, output divider_m, output pll_n, output doubled,
    output error_khz, output found, input ready
  );
  modport sink (
    input valid, input divider_m, input pll_n, input doubled,
    input error_khz, input found, output ready
  );
endinterface

// File: rtl/core/pcds_div.sv
module pcds_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcds_pkg::DdW-1:0]  dividend_i,
  input  logic [pcds_pkg::DsW-1:0]  divisor_i,
  output logic [pcds_pkg::DdW-1:0]  quotient_o,
  output logic                      busy_o,
  output logic                      done_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [pcds_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [pcds_pkg::DdW-1:0]         dd_q, dd_d;
  logic [pcds_pkg::DsW-1:0]         ds_q, ds_d;
  logic [pcds_pkg::DsW-1:0]         rem_q, rem_d;
  logic [pcds_pkg::DsW:0]           rem_sh;
  logic [pcds_pkg::DsW:0]           rem_sub;
  logic                             ge;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh  = {rem_q, dd_q[pcds_pkg::DdW-1]};
    ge      = rem_sh >= {1'b0, ds_q};
    rem_sub = rem_sh - {1'b0, ds_q};
  end

  // Sequencing: one quotient bit per cycle, the quotient shifts in behind the dividend.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dd_d   = dd_q;
    ds_d   = ds_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dd_d   = dividend_i;
      ds_d   = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[pcds_pkg::DsW-1:0] : rem_sh[pcds_pkg::DsW-1:0];
      dd_d  = {dd_q[pcds_pkg::DdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pcds_pkg::DivCntW'(pcds_pkg::DdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q  <= dd_d;
    ds_q  <= ds_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dd_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

// File: rtl/core/pcds_dpath.sv
module pcds_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcds_pkg::ctrl_cmd_t         cmd_i,
  output pcds_pkg::dp_sts_t           sts_o,
  input  logic                        par_i,
  input  logic                        channel_i,
  input  logic [pcds_pkg::ClkW-1:0]   pclk_i,
  output logic [6:0]                  divider_m_o,
  output logic [pcds_pkg::NW-1:0]     pll_n_o,
  output logic                        doubled_o,
  output logic [pcds_pkg::ErrW-1:0]   error_khz_o,
  output logic                        found_o
);

  localparam logic [pcds_pkg::ProdW-1:0] LoPlain =
    pcds_pkg::ProdW'(pcds_pkg::NMin * pcds_pkg::KPlain);
  localparam logic [pcds_pkg::ProdW-1:0] HiPlain =
    pcds_pkg::ProdW'((pcds_pkg::NMax + 1) * pcds_pkg::KPlain);
  localparam logic [pcds_pkg::ProdW-1:0] LoDbl =
    pcds_pkg::ProdW'(pcds_pkg::NMin * pcds_pkg::KDbl);
  localparam logic [pcds_pkg::ProdW-1:0] HiDbl =
    pcds_pkg::ProdW'((pcds_pkg::NMax + 1) * pcds_pkg::KDbl);

  logic [pcds_pkg::ClkW-1:0]  clk_q;
  logic [pcds_pkg::MW-1:0]    m_q;
  logic [pcds_pkg::MW-1:0]    hi_q;
  logic                       dbl_q;
  logic [pcds_pkg::ProdW-1:0] prod_q;
  logic [pcds_pkg::NW-1:0]    n_q;
  logic [pcds_pkg::MW-1:0]    best_m_q;
  logic [pcds_pkg::NW-1:0]    best_n_q;
  logic                       best_dbl_q;
  logic [pcds_pkg::ErrW-1:0]  best_diff_q;
  logic [6:0]                 out_m_q;
  logic [pcds_pkg::NW-1:0]    out_n_q;
  logic                       out_dbl_q;
  logic [pcds_pkg::ErrW-1:0]  out_err_q;
  logic                       out_found_q;

  logic [pcds_pkg::DsW-1:0]   k;
  logic [pcds_pkg::DdW-1:0]   kn;
  logic [pcds_pkg::QW-1:0]    q_x;
  logic [pcds_pkg::RqW-1:0]   q_prod;
  logic [pcds_pkg::NW-1:0]    n_est;
  logic [pcds_pkg::DdW-1:0]   div_dd;
  logic [pcds_pkg::DsW-1:0]   div_ds;
  logic [pcds_pkg::DdW-1:0]   quo;
  logic                       div_busy;
  logic                       div_done;
  logic [pcds_pkg::ClkW-1:0]  diff;
  logic [pcds_pkg::MW-1:0]    lo_sel;
  logic [pcds_pkg::MW-1:0]    hi_sel;
  logic                       in_range;

  // Step size of the current candidate and the window that n must fall in.
  always_comb begin
    k  = dbl_q ? pcds_pkg::DsW'(pcds_pkg::KDbl) : pcds_pkg::DsW'(pcds_pkg::KPlain);
    kn = pcds_pkg::DdW'(k) * pcds_pkg::DdW'(n_q);
    if (dbl_q) begin
      in_range = (prod_q >= LoDbl) && (prod_q < HiDbl);
    end else begin
      in_range = (prod_q >= LoPlain) && (prod_q < HiPlain);
    end
  end

  // n = m * clock / K: shift out the power of two in K, then multiply by the
  // scaled reciprocal of 375. Only used when n falls in the fitting window.
  always_comb begin
    q_x    = dbl_q ? pcds_pkg::QW'(prod_q >> pcds_pkg::KShDbl)
                   : pcds_pkg::QW'(prod_q >> pcds_pkg::KShPlain);
    q_prod = pcds_pkg::RqW'(q_x) * pcds_pkg::RqW'(pcds_pkg::RecipK);
    n_est  = pcds_pkg::NW'(q_prod >> pcds_pkg::RecipShift);
  end

  // Divider operands: K * n / m gives the achieved clock.
  assign div_dd = kn;
  assign div_ds = pcds_pkg::DsW'(m_q);

  pcds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dd),
    .divisor_i  (div_ds),
    .quotient_o (quo),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // Divider range for the requested channel.
  always_comb begin
    if (channel_i) begin
      lo_sel = pcds_pkg::MW'(pcds_pkg::Ch1Lo);
      hi_sel = pcds_pkg::MW'(pcds_pkg::Ch1Hi);
    end else if (par_i) begin
      lo_sel = pcds_pkg::MW'(pcds_pkg::ParLo);
      hi_sel = pcds_pkg::MW'(pcds_pkg::MaxDivider);
    end else begin
      lo_sel = pcds_pkg::MW'(pcds_pkg::SerM);
      hi_sel = pcds_pkg::MW'(pcds_pkg::SerM);
    end
  end

  // Shortfall of the achieved clock; it never goes negative.
  assign diff = clk_q - quo;

  // Search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      clk_q       <= pclk_i;
      m_q         <= lo_sel;
      hi_q        <= hi_sel;
      dbl_q       <= 1'b0;
      best_m_q    <= '0;
      best_n_q    <= '0;
      best_dbl_q  <= 1'b0;
      best_diff_q <= pcds_pkg::NoFitError;
    end else begin
      if (cmd_i.mul) begin
        prod_q <= pcds_pkg::ProdW'(m_q) * pcds_pkg::ProdW'(clk_q);
      end
      if (cmd_i.set_dbl) begin
        dbl_q <= 1'b1;
      end
      if (cmd_i.next_m) begin
        m_q   <= m_q + pcds_pkg::MW'(1);
        dbl_q <= 1'b0;
      end
      if (cmd_i.cap_n) begin
        n_q <= n_est;
      end
      if (cmd_i.cmp && (pcds_pkg::ErrW'(diff) < best_diff_q)) begin
        best_diff_q <= pcds_pkg::ErrW'(diff);
        best_m_q    <= m_q;
        best_n_q    <= n_q;
        best_dbl_q  <= dbl_q;
      end
    end
  end

  // Output word register, held until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_m_q     <= best_m_q[6:0];
      out_n_q     <= best_n_q;
      out_dbl_q   <= best_dbl_q;
      out_err_q   <= best_diff_q;
      out_found_q <= best_m_q != '0;
    end
  end

  always_comb begin
    sts_o.in_range = in_range;
    sts_o.m_odd    = m_q[0];
    sts_o.m_last   = m_q == hi_q;
    sts_o.dbl      = dbl_q;
    sts_o.div_busy = div_busy;
    sts_o.div_done = div_done;
  end

  assign divider_m_o = out_m_q;
  assign pll_n_o     = out_n_q;
  assign doubled_o   = out_dbl_q;
  assign error_khz_o = out_err_q;
  assign found_o     = out_found_q;

endmodule

// File: rtl/core/pcds_ctrl.sv
module pcds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pcds_pkg::dp_sts_t    sts_i,
  output pcds_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StAch  = 3'd4;
  localparam logic [2:0] StDivA = 3'd5;
  localparam logic [2:0] StNext = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Search sequencing: per divider one product, then up to two candidates.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.init = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        if (sts_i.in_range) begin
          cmd_o.cap_n = 1'b1;
          state_d     = StAch;
        end else begin
          state_d = StNext;
        end
      end
      StAch: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDivA;
      end
      StDivA: begin
        if (sts_i.div_done) begin
          cmd_o.cmp = 1'b1;
          state_d   = StNext;
        end
      end
      StNext: begin
        if (!sts_i.dbl && sts_i.m_odd) begin
          cmd_o.set_dbl = 1'b1;
          state_d       = StChk;
        end else if (sts_i.m_last) begin
          state_d = StDone;
        end else begin
          cmd_o.next_m = 1'b1;
          state_d      = StMul;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/pixel_clock_divider_search.sv
// Pixel clock divider search. Each input word (channel, pixel clock in kHz) yields one
// result word with the post divider m, the PLL multiplier n in 3 MHz steps, the doubled
// flag, the shortfall in kHz and a found flag. The search visits each divider in the
// channel's range in turn: it first forms m times the clock, then each candidate (plain,
// and doubled for odd m) is dropped when n falls outside 9..127 or, when it fits, takes
// one 20-step pass through the serial divider that forms the achieved clock. Channel 0
// searches dividers 6..127 on a parallel panel and only the single divider of seven on a
// serial one; channel 1 searches 1..15. One word is searched at a time; a finished word
// waits in the output register while the next word is accepted. The parallel-interface
// register resets to 1 and is to be written by the user only while no search is running;
// the block itself does not enforce this.
module pixel_clock_divider_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcds_cfg_if.sink    cfg_ch,
  pcds_in_if.sink     in_ch,
  pcds_out_if.source  out_ch
);

  logic                 par_q;
  pcds_pkg::ctrl_cmd_t  cmd;
  pcds_pkg::dp_sts_t    sts;

  // Parallel-interface configuration register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b1;
    end else if (cfg_ch.valid) begin
      par_q <= cfg_ch.parallel_interface;
    end
  end

  pcds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcds_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .par_i       (par_q),
    .channel_i   (in_ch.channel),
    .pclk_i      (in_ch.pixel_clock_khz),
    .divider_m_o (out_ch.divider_m),
    .pll_n_o     (out_ch.pll_n),
    .doubled_o   (out_ch.doubled),
    .error_khz_o (out_ch.error_khz),
    .found_o     (out_ch.found)
  );

  // A division is never started while the divider is still working.
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("division started while divider busy");

  // A word with no fit carries the no-fit pattern.
  a_no_fit_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.found) |->
      (out_ch.error_khz == pcds_pkg::NoFitError && out_ch.pll_n == '0 && !out_ch.doubled))
    else $error("no-fit word has stray fields");

  // A chosen multiplier always lies in the legal range.
  a_n_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.found) |->
      (out_ch.pll_n >= pcds_pkg::NW'(pcds_pkg::NMin)))
    else $error("chosen multiplier below range");

  // A compare only follows a finished division.
  a_cmp_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cmp |-> sts.div_done)
    else $error("candidate compared without a finished division");

endmodule
